// ===== rtl/bpc_pkg.sv =====
package bpc_pkg;

    localparam int BUTTONS_DEF = 6;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DOWN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PIN_MAP     = 3'd5;

    localparam int MS_W      = 23;
    localparam int PIN_MAP_W = 24;

    // down time in ms: floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for any 32-bit x
    localparam int              DIV_SHIFT = 38;
    localparam int              MAGIC_W   = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
    localparam int              PROD_W    = 32 + MAGIC_W;

    // event codes
    localparam logic [2:0] EV_STATUS = 3'd0;
    localparam logic [2:0] EV_PRESS  = 3'd1;
    localparam logic [2:0] EV_HOLD   = 3'd2;
    localparam logic [2:0] EV_LONG   = 3'd3;
    localparam logic [2:0] EV_REPEAT = 3'd4;

    // button phases
    localparam logic [2:0] PH_UP   = 3'd0;
    localparam logic [2:0] PH_DOWN = 3'd1;
    localparam logic [2:0] PH_HOLD = 3'd2;
    localparam logic [2:0] PH_LONG = 3'd3;
    localparam logic [2:0] PH_MAX  = 3'd4;

    typedef struct packed {
        logic [15:0] pin_sample;
        logic [31:0] time_us;
    } t_in_word;

    typedef struct packed {
        logic [2:0] button_index;
        logic [2:0] event_kind;
        logic       keep_polling;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [15:0]          short_press_ms;
        logic [15:0]          hold_ms;
        logic [15:0]          long_hold_ms;
        logic [MS_W-1:0]      max_down_ms;
        logic [7:0]           repeat_polls;
        logic [PIN_MAP_W-1:0] pin_map;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        short_press_ms: 16'd25,
        hold_ms:        16'd2000,
        long_hold_ms:   16'd5000,
        max_down_ms:    23'd60000,
        repeat_polls:   8'd4,
        pin_map:        24'h543210
    };

endpackage

// ===== rtl/bpc_front.sv =====
module bpc_front import bpc_pkg::*; #(
    parameter int BUTTONS = BUTTONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_word           i_in_word,
    output logic               o_q_valid,
    output logic [BUTTONS-1:0] o_q_pressed,
    output logic [31:0]        o_q_time,
    input  logic               i_q_pop
);

    logic [BUTTONS-1:0] w_pressed;

    // pin lookup per button, buttons past the map read pin bit 0
    for (genvar g = 0; g < BUTTONS; g++) begin : g_btn
        if (4 * g < PIN_MAP_W) begin : g_mapped
            assign w_pressed[g] = ~i_in_word.pin_sample[i_cfg.pin_map[4*g +: 4]];
        end else begin : g_unmapped
            assign w_pressed[g] = ~i_in_word.pin_sample[0];
        end
    end

    // two-word queue
    logic [BUTTONS-1:0] r_q_pressed [2];
    logic [31:0]        r_q_time    [2];
    logic               r_wr;
    logic               r_rd;
    logic [1:0]         r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_pressed = r_q_pressed[r_rd];
    assign o_q_time    = r_q_time[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_pressed[r_wr] <= w_pressed;
            r_q_time[r_wr]    <= i_in_word.time_us;
        end
    end

endmodule

// ===== rtl/bpc_back.sv =====
module bpc_back import bpc_pkg::*; #(
    parameter int BUTTONS = BUTTONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  logic [BUTTONS-1:0] i_q_pressed,
    input  logic [31:0]        i_q_time,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_word          o_out_word
);

    localparam int SW = $clog2(BUTTONS + 1);
    localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [SW-1:0] STATUS_SLOT = SW'(BUTTONS);

    // per-button state
    logic [2:0]  r_phase      [BUTTONS];
    logic [31:0] r_press_time [BUTTONS];
    logic [7:0]  r_rep        [BUTTONS];

    logic        w_adv;
    logic        w_issue;
    logic [SW-1:0] r_slot;
    logic [BW-1:0] w_idx;
    logic [31:0]   w_diff;
    logic [PROD_W-1:0] w_prod;

    // stage a: a button or the status slot per cycle unless stalled, ms scaling
    logic            r_a_valid;
    logic            r_a_status;
    logic [BW-1:0]   r_a_idx;
    logic            r_a_pressed;
    logic [31:0]     r_a_time;
    logic [MS_W-1:0] r_a_ms;

    logic      r_keep;
    logic      r_out_valid;
    t_out_word r_out_word;

    assign w_adv   = !r_out_valid || !i_out_stall;
    assign w_issue = w_adv && i_q_valid;
    assign o_q_pop = w_issue && (r_slot == STATUS_SLOT);
    assign w_idx   = (r_slot == STATUS_SLOT) ? '0 : r_slot[BW-1:0];
    assign w_diff  = i_q_time - r_press_time[w_idx];
    assign w_prod  = PROD_W'(w_diff) * PROD_W'(DIV_MAGIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_q_valid;
            if (i_q_valid) begin
                r_slot <= (r_slot == STATUS_SLOT) ? '0 : r_slot + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_a_status  <= (r_slot == STATUS_SLOT);
            r_a_idx     <= w_idx;
            r_a_pressed <= i_q_pressed[w_idx];
            r_a_time    <= i_q_time;
            r_a_ms      <= w_prod[DIV_SHIFT +: MS_W];
        end
    end

    // stage b: phase update and event
    logic [2:0] b_phase;
    logic [2:0] n_phase;
    logic [7:0] b_rep;
    logic [7:0] b_rep_inc;
    logic [7:0] n_rep;
    logic       b_set_time;
    logic       b_keep;
    logic       b_emit;
    logic [2:0] b_kind;

    always_comb begin
        b_phase    = r_phase[r_a_idx];
        b_rep      = r_rep[r_a_idx];
        b_rep_inc  = b_rep + 8'd1;
        n_phase    = b_phase;
        n_rep      = b_rep;
        b_set_time = 1'b0;
        b_keep     = 1'b0;
        b_emit     = 1'b0;
        b_kind     = EV_STATUS;
        if (r_a_status) begin
            b_emit = 1'b1;
        end else if (b_phase == PH_UP) begin
            if (r_a_pressed) begin
                b_keep     = 1'b1;
                b_set_time = 1'b1;
                n_phase    = PH_DOWN;
            end
        end else if (r_a_ms < i_cfg.max_down_ms) begin
            b_keep = 1'b1;
            if (r_a_pressed) begin
                priority if (b_phase == PH_DOWN && r_a_ms > MS_W'(i_cfg.hold_ms)) begin
                    n_phase = PH_HOLD;
                    n_rep   = 8'd0;
                    b_emit  = 1'b1;
                    b_kind  = EV_HOLD;
                end else if (b_phase == PH_HOLD && r_a_ms > MS_W'(i_cfg.long_hold_ms)) begin
                    n_phase = PH_LONG;
                    b_emit  = 1'b1;
                    b_kind  = EV_LONG;
                end else if (b_phase == PH_HOLD || b_phase == PH_LONG) begin
                    n_rep = b_rep_inc;
                    if (b_rep_inc == i_cfg.repeat_polls) begin
                        n_rep  = 8'd0;
                        b_emit = 1'b1;
                        b_kind = EV_REPEAT;
                    end
                end else begin
                    n_phase = b_phase;
                end
            end else begin
                if (b_phase == PH_DOWN && r_a_ms > MS_W'(i_cfg.short_press_ms)) begin
                    b_emit = 1'b1;
                    b_kind = EV_PRESS;
                end
                n_phase = PH_UP;
            end
        end else begin
            // expired: stuck while pressed, back to up on release, silently
            n_phase = r_a_pressed ? PH_MAX : PH_UP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUTTONS; i++) begin
                r_phase[i] <= PH_UP;
            end
            r_keep      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_a_valid && b_emit;
            if (r_a_valid) begin
                if (r_a_status) begin
                    r_keep <= 1'b0;
                end else begin
                    r_phase[r_a_idx] <= n_phase;
                    if (b_keep) begin
                        r_keep <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_a_valid && !r_a_status) begin
            r_rep[r_a_idx] <= n_rep;
            if (b_set_time) begin
                r_press_time[r_a_idx] <= r_a_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_a_status) begin
                r_out_word.button_index <= 3'd0;
                r_out_word.event_kind   <= EV_STATUS;
                r_out_word.keep_polling <= r_keep;
                r_out_word.last         <= 1'b1;
            end else begin
                r_out_word.button_index <= 3'(r_a_idx);
                r_out_word.event_kind   <= b_kind;
                r_out_word.keep_polling <= 1'b0;
                r_out_word.last         <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/button_press_classifier_unit.sv =====
// button press classifier
// input channel: one word per poll (pin sample, active low, and a microsecond
// timestamp), taken when i_in_valid is high and o_in_stall is low.
// output channel: event words in button order (press, hold, long hold, hold
// repeat), then one status word with last set and keep_polling telling whether
// any button was down, or released at this poll, within the max time. taken
// when o_out_valid is high and i_out_stall is low.
// config channel: i_cfg_index selects short_press_ms, hold_ms, long_hold_ms,
// max_down_ms, repeat_polls, pin_map (0..5); always ready, write only when idle.
// the back end walks one button per cycle plus the status slot through its
// sequencer while a poll is queued and the output is not stalled.
// an event word for a button passes through the queue, the ms scaling stage
// and the event stage into the output register; the status word follows the
// button words of its poll.
// a two-word queue sits between the front end and the back end, so polls are
// still taken while the receiver stalls until the queue fills; a stall of a
// valid output word freezes the back end and holds that word.
// reset: all buttons up, config back to defaults, queue and output empty.
module button_press_classifier_unit import bpc_pkg::*; #(
    parameter int BUTTONS = BUTTONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SHORT_PRESS: r_cfg.short_press_ms <= i_cfg_data[15:0];
                REG_HOLD:        r_cfg.hold_ms        <= i_cfg_data[15:0];
                REG_LONG_HOLD:   r_cfg.long_hold_ms   <= i_cfg_data[15:0];
                REG_MAX_DOWN:    r_cfg.max_down_ms    <= i_cfg_data[MS_W-1:0];
                REG_REPEAT:      r_cfg.repeat_polls   <= i_cfg_data[7:0];
                REG_PIN_MAP:     r_cfg.pin_map        <= i_cfg_data[PIN_MAP_W-1:0];
                default: ;
            endcase
        end
    end

    logic               w_q_valid;
    logic [BUTTONS-1:0] w_q_pressed;
    logic [31:0]        w_q_time;
    logic               w_q_pop;

    bpc_front #(.BUTTONS(BUTTONS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_q_valid   (w_q_valid),
        .o_q_pressed (w_q_pressed),
        .o_q_time    (w_q_time),
        .i_q_pop     (w_q_pop)
    );

    bpc_back #(.BUTTONS(BUTTONS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_pressed (w_q_pressed),
        .i_q_time    (w_q_time),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/bpc_checker.sv =====
module bpc_checker import bpc_pkg::*; #(
    parameter int BUTTONS = BUTTONS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_word             o_out_word
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // the closing word of a poll is a status word on button zero
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.last |->
            o_out_word.event_kind == EV_STATUS && o_out_word.button_index == 3'd0)
        else $error("malformed status word");

    // event words name a real button and a real event
    a_event_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |->
            !o_out_word.keep_polling && int'(o_out_word.button_index) < BUTTONS &&
            (o_out_word.event_kind == EV_PRESS || o_out_word.event_kind == EV_HOLD ||
             o_out_word.event_kind == EV_LONG || o_out_word.event_kind == EV_REPEAT))
        else $error("malformed event word");

endmodule

bind button_press_classifier_unit bpc_checker #(.BUTTONS(BUTTONS)) u_bpc_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bpc_pkg::*;

    localparam int STUCK_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    button_press_classifier_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // per-button classifier state plus the event words still owed by the block
    class event_board;
        t_cfg        regs;
        logic [2:0]  phase_of [BUTTONS_DEF];
        logic [31:0] pressed_at [BUTTONS_DEF];
        logic [7:0]  repeat_ticks [BUTTONS_DEF];
        t_out_word   due_words [$];
        int          mismatches;

        function new();
            regs = CFG_RESET;
            for (int b = 0; b < BUTTONS_DEF; b++) begin
                phase_of[b]     = PH_UP;
                pressed_at[b]   = '0;
                repeat_ticks[b] = '0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SHORT_PRESS: regs.short_press_ms = data[15:0];
                REG_HOLD:        regs.hold_ms        = data[15:0];
                REG_LONG_HOLD:   regs.long_hold_ms   = data[15:0];
                REG_MAX_DOWN:    regs.max_down_ms    = data[MS_W-1:0];
                REG_REPEAT:      regs.repeat_polls   = data[7:0];
                REG_PIN_MAP:     regs.pin_map        = data[PIN_MAP_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_word(int b, logic [2:0] kind, logic keep, logic fin);
            t_out_word w;
            w.button_index = b[2:0];
            w.event_kind   = kind;
            w.keep_polling = keep;
            w.last         = fin;
            due_words.push_back(w);
        endfunction

        function void classify_poll(t_in_word poll);
            logic [3:0]  pin_idx;
            logic        down_now;
            logic [31:0] held_ms;
            logic        keep;
            keep = 1'b0;
            for (int b = 0; b < BUTTONS_DEF; b++) begin
                pin_idx  = regs.pin_map[4*b +: 4];
                down_now = !poll.pin_sample[pin_idx];
                if (phase_of[b] == PH_UP) begin
                    if (down_now) begin
                        keep          = 1'b1;
                        pressed_at[b] = poll.time_us;
                        phase_of[b]   = PH_DOWN;
                    end
                end else begin
                    held_ms = (poll.time_us - pressed_at[b]) / 32'd1000;
                    if (held_ms < 32'(regs.max_down_ms)) begin
                        keep = 1'b1;
                        if (down_now) begin
                            if (phase_of[b] == PH_DOWN && held_ms > 32'(regs.hold_ms)) begin
                                phase_of[b]     = PH_HOLD;
                                repeat_ticks[b] = '0;
                                push_word(b, EV_HOLD, 1'b0, 1'b0);
                            end else if (phase_of[b] == PH_HOLD &&
                                         held_ms > 32'(regs.long_hold_ms)) begin
                                phase_of[b] = PH_LONG;
                                push_word(b, EV_LONG, 1'b0, 1'b0);
                            end else if (phase_of[b] == PH_HOLD || phase_of[b] == PH_LONG) begin
                                repeat_ticks[b] = repeat_ticks[b] + 8'd1;
                                if (repeat_ticks[b] == regs.repeat_polls) begin
                                    repeat_ticks[b] = '0;
                                    push_word(b, EV_REPEAT, 1'b0, 1'b0);
                                end
                            end
                        end else begin
                            if (phase_of[b] == PH_DOWN && held_ms > 32'(regs.short_press_ms))
                                push_word(b, EV_PRESS, 1'b0, 1'b0);
                            phase_of[b] = PH_UP;
                        end
                    end else begin
                        // stuck: silent, no keep alive
                        phase_of[b] = down_now ? PH_MAX : PH_UP;
                    end
                end
            end
            push_word(0, EV_STATUS, keep, 1'b1);
        endfunction

        task report(string what);
            if (mismatches < 30)
                $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                report($sformatf("unexpected word btn %0d kind %0d",
                                 got.button_index, got.event_kind));
            end else begin
                want = due_words.pop_front();
                if (got.button_index !== want.button_index)
                    report($sformatf("button_index got %0d want %0d",
                                     got.button_index, want.button_index));
                if (got.event_kind !== want.event_kind)
                    report($sformatf("event_kind got %0d want %0d (btn %0d)",
                                     got.event_kind, want.event_kind, want.button_index));
                if (got.keep_polling !== want.keep_polling)
                    report($sformatf("keep_polling got %0b want %0b",
                                     got.keep_polling, want.keep_polling));
                if (got.last !== want.last)
                    report($sformatf("last got %0b want %0b", got.last, want.last));
            end
        endtask

        function int pending();
            return due_words.size();
        endfunction
    endclass

    event_board  board = new();
    logic [15:0] pin_lvl;
    logic [31:0] clock_us;
    bit          no_idle;
    int          stuck_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                board.classify_poll(i_in_word);
            if (o_out_valid && !i_out_stall)
                board.check_word(o_out_word);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
            $display("** button_press_classifier_unit: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure in short bursts
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (no_idle) begin
                stall_left = 0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_poll(input logic [15:0] pins, input logic [31:0] stamp);
        t_in_word w;
        w.pin_sample = pins;
        w.time_us    = stamp;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // pins drift a few bits per poll so presses last many polls; held pins stay low
    task automatic run_phase(input t_cfg c, input int count, input int step_us,
                             input logic [15:0] held, input int flip_div, input bit jumps,
                             input bit write_cfg, input bit clear_first, input int calm_tail);
        logic [31:0] step;
        logic [15:0] pins;
        int          r;
        if (write_cfg) begin
            drain();
            set_reg(REG_SHORT_PRESS, CFG_DATA_W'(c.short_press_ms));
            set_reg(REG_HOLD,        CFG_DATA_W'(c.hold_ms));
            set_reg(REG_LONG_HOLD,   CFG_DATA_W'(c.long_hold_ms));
            set_reg(REG_MAX_DOWN,    CFG_DATA_W'(c.max_down_ms));
            set_reg(REG_REPEAT,      CFG_DATA_W'(c.repeat_polls));
            set_reg(REG_PIN_MAP,     CFG_DATA_W'(c.pin_map));
        end
        if (clear_first) begin
            clock_us = clock_us + 32'(step_us);
            send_poll(16'hFFFF, clock_us);
        end
        for (int k = 0; k < count; k++) begin
            if (k >= count - calm_tail)
                no_idle = 1'b1;
            for (int p = 0; p < 16; p++)
                if ($urandom_range(1, flip_div) == 1)
                    pin_lvl[p] = ~pin_lvl[p];
            r = $urandom_range(0, 31);
            if (jumps && r == 0)
                step = $urandom();
            else if (r == 1)
                step = '0;
            else
                step = $urandom_range(step_us / 2, step_us * 3 / 2);
            clock_us = clock_us + step;
            pins = (r == 2 || r == 3) ? 16'($urandom()) : pin_lvl;
            send_poll(pins & ~held, clock_us);
        end
    endtask

    initial begin
        t_cfg setting;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        no_idle     = 1'b0;
        pin_lvl     = 16'hFFFF;
        clock_us    = 32'd200000000;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed polls at reset settings
        send_poll(16'hFFFF, 32'd0);
        send_poll(16'h0000, 32'd1000);
        send_poll(16'hFFFF, 32'd11000);          // too short to count
        send_poll(16'h0000, 32'd100000);
        send_poll(16'hFFFF, 32'd126000);         // all six report a press
        send_poll(16'hFFFE, 32'd200000);
        send_poll(16'hFFFE, 32'd2201000);        // hold
        send_poll(16'hFFFE, 32'd2226000);
        send_poll(16'hFFFE, 32'd2251000);
        send_poll(16'hFFFE, 32'd2276000);
        send_poll(16'hFFFE, 32'd2301000);        // repeat
        send_poll(16'hFFFE, 32'd5300000);        // long hold
        send_poll(16'hFFFF, 32'd5400000);        // release from long hold, silent
        send_poll(16'hFFFD, 32'd6000000);
        send_poll(16'hFFFD, 32'd66000000);       // stuck
        send_poll(16'hFFFD, 32'd6050000);        // down time back under the limit
        send_poll(16'hFFFF, 32'd6060000);
        send_poll(16'hFFFB, 32'hFFFFF000);
        send_poll(16'hFFFF, 32'h00010000);       // press across the timestamp wrap
        send_poll(16'hFFF7, 32'hFFFFFFFF);
        send_poll(16'hFFF7, 32'd70000000);
        send_poll(16'hFFFF, 32'd75000000);       // stuck then released
        send_poll(16'hFFEF, 32'd80000000);
        send_poll(16'hFFFF, 32'd150000000);      // expires on release

        run_phase(CFG_RESET, 15, 250000, 16'h0000, 6, 1'b1, 1'b0, 1'b0, 0);

        setting = '{short_press_ms: 16'd5, hold_ms: 16'd50, long_hold_ms: 16'd120,
                    max_down_ms: 23'd400, repeat_polls: 8'd3, pin_map: 24'h102354};
        run_phase(setting, 30, 10000, 16'h0000, 5, 1'b1, 1'b1, 1'b0, 0);

        setting = '{short_press_ms: 16'd0, hold_ms: 16'd0, long_hold_ms: 16'd0,
                    max_down_ms: 23'd0, repeat_polls: 8'd1, pin_map: 24'h000000};
        run_phase(setting, 15, 1000, 16'h0000, 3, 1'b1, 1'b1, 1'b0, 0);

        // pin 15 held through this phase and the next to walk the repeat counter around
        setting = '{short_press_ms: 16'hFFFF, hold_ms: 16'hFFFF, long_hold_ms: 16'hFFFF,
                    max_down_ms: 23'd4294967, repeat_polls: 8'd255, pin_map: 24'hFFFFFF};
        run_phase(setting, 55, 5000000, 16'h8000, 6, 1'b0, 1'b1, 1'b1, 0);

        setting = '{short_press_ms: 16'd10, hold_ms: 16'd100, long_hold_ms: 16'd200,
                    max_down_ms: 23'd4294967, repeat_polls: 8'd0, pin_map: 24'hFFF210};
        run_phase(setting, 230, 2000, 16'h8000, 8, 1'b0, 1'b1, 1'b0, 80);

        drain();
        repeat (4) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("** button_press_classifier_unit: PASSED **");
        else
            $display("** button_press_classifier_unit: FAILED **");
        $finish;
    end

endmodule

// ===== button_press_classifier_unit.f =====
rtl/bpc_pkg.sv
rtl/bpc_front.sv
rtl/bpc_back.sv
rtl/button_press_classifier_unit.sv
rtl/bpc_checker.sv
verif/tb.sv
